### rtl/mfbp_pkg.sv
// Shared types and constants for the MSB-first bit packer.
`default_nettype none

package mfbp_pkg;

  localparam int VALUE_W        = 32;
  localparam int COUNT_W        = 6;
  localparam int BYTE_W         = 8;
  localparam int PEND_CNT_W     = 3;
  localparam int MAX_BYTES      = 4;
  localparam int MAX_FIELD_BITS = 32;
  // Counts above this are ignored: the field limit, never beyond the value width.
  localparam int COUNT_LIMIT    = (MAX_FIELD_BITS < VALUE_W) ? MAX_FIELD_BITS : VALUE_W;
  localparam int QUEUE_DEPTH_DEF = 2;

  // One queued job: the completed bytes, earliest in the top byte, and the
  // index of the final byte.
  typedef struct packed {
    logic [MAX_BYTES*BYTE_W-1:0] bytes;
    logic [1:0]                  last_idx;
  } mfbp_entry_t;

endpackage

`default_nettype wire

### rtl/mfbp_if.sv
// Channel interfaces for the input words and the output bytes.
`default_nettype none

interface mfbp_in_if;
  logic                          valid;
  logic                          ready;
  logic [mfbp_pkg::VALUE_W-1:0]  value;
  logic [mfbp_pkg::COUNT_W-1:0]  bit_count;

  modport source (output valid, output value, output bit_count, input ready);
  modport sink   (input valid, input value, input bit_count, output ready);
endinterface

interface mfbp_out_if;
  logic                         valid;
  logic                         ready;
  logic [mfbp_pkg::BYTE_W-1:0]  out_byte;
  logic                         last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

### rtl/mfbp_front.sv
// Front end: accepts words, merges them with the pending bits, queues full bytes.
`default_nettype none

module mfbp_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  mfbp_in_if.sink                    in_ch,
  input  wire logic                  q_full,
  output logic                       push,
  output mfbp_pkg::mfbp_entry_t      push_entry
);

  localparam int VW = mfbp_pkg::VALUE_W;
  localparam int BW = mfbp_pkg::BYTE_W;
  localparam int CW = mfbp_pkg::COUNT_W;
  localparam int PW = mfbp_pkg::PEND_CNT_W;
  localparam int SW = VW + BW;

  logic [BW-1:0]   pend_bits_r, pend_bits_nxt;
  logic [PW-1:0]   pend_cnt_r, pend_cnt_nxt;
  logic            accept;
  logic            usable;
  logic [4:0]      left_sh;
  logic [VW-1:0]   v_left;
  logic [SW-1:0]   stream;
  logic [CW-1:0]   total;
  logic [2:0]      nbytes;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    usable  = (in_ch.bit_count != '0) &&
              (in_ch.bit_count <= CW'(mfbp_pkg::COUNT_LIMIT));
    // Left-align the new bits; the shift drops the unused high value bits.
    left_sh = 5'(CW'(VW) - in_ch.bit_count);
    v_left  = in_ch.value << left_sh;
    stream  = {pend_bits_r, {VW{1'b0}}} | ({v_left, {BW{1'b0}}} >> pend_cnt_r);
    total   = CW'(pend_cnt_r) + in_ch.bit_count;
    nbytes  = total[CW-1:PW];

    unique case (nbytes)
      3'd0:    pend_bits_nxt = stream[SW-1 -: BW];
      3'd1:    pend_bits_nxt = stream[SW-1-BW -: BW];
      3'd2:    pend_bits_nxt = stream[SW-1-2*BW -: BW];
      3'd3:    pend_bits_nxt = stream[SW-1-3*BW -: BW];
      default: pend_bits_nxt = stream[SW-1-4*BW -: BW];
    endcase
    pend_cnt_nxt = total[PW-1:0];

    push                = accept && usable && (nbytes != 3'd0);
    push_entry.bytes    = stream[SW-1:BW];
    push_entry.last_idx = 2'(nbytes - 3'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end else if (accept && usable) begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

  a_ignored_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !usable) |=> ($stable(pend_bits_r) && $stable(pend_cnt_r)))
    else $error("ignored word changed the pending bits");

  a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (accept && !q_full))
    else $error("queue push without an accepted word");

  a_unused_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_cnt_r == '0) |-> (pend_bits_r == '0))
    else $error("pending byte holds stray bits");

endmodule

`default_nettype wire

### rtl/mfbp_queue.sv
// Short queue of byte jobs between the front and back ends.
`default_nettype none

module mfbp_queue #(
  parameter int DEPTH = mfbp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire mfbp_pkg::mfbp_entry_t push_entry,
  input  wire logic                  pop,
  output mfbp_pkg::mfbp_entry_t      head,
  output logic                       full,
  output logic                       empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mfbp_pkg::mfbp_entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from an empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

### rtl/mfbp_back.sv
// Back end: sends queued bytes one per ready cycle and flags the last.
`default_nettype none

module mfbp_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mfbp_pkg::mfbp_entry_t head,
  input  wire logic                  q_empty,
  output logic                       pop,
  mfbp_out_if.source                 out_ch
);

  localparam int BW = mfbp_pkg::BYTE_W;
  localparam int JW = mfbp_pkg::MAX_BYTES * BW;

  logic          busy_r;
  logic [1:0]    left_r;
  logic [JW-1:0] bytes_r;
  logic          out_fire;
  logic          finishing;

  always_comb begin
    out_fire  = busy_r && out_ch.ready;
    finishing = !busy_r || (out_fire && (left_r == 2'd0));
    pop       = finishing && !q_empty;
  end

  assign out_ch.valid       = busy_r;
  assign out_ch.out_byte    = bytes_r[JW-1 -: BW];
  assign out_ch.last_of_run = (left_r == 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      left_r <= '0;
    end else if (pop) begin
      busy_r <= 1'b1;
      left_r <= head.last_idx;
    end else if (finishing) begin
      busy_r <= 1'b0;
    end else if (out_fire) begin
      left_r <= left_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      bytes_r <= head.bytes;
    end else if (out_fire) begin
      bytes_r <= {bytes_r[JW-BW-1:0], {BW{1'b0}}};
    end
  end

  a_pop_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (!busy_r || (out_fire && (left_r == 2'd0))))
    else $error("job loaded over one still in progress");

  a_last_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && (left_r == 2'd0) && q_empty) |=> !busy_r)
    else $error("back end stayed busy after the final byte");

endmodule

`default_nettype wire

### rtl/msb_first_bit_packer.sv
// Top level of the MSB-first bit packer: front end, job queue and back end.
//
//  Channel | Dir | Word                               | Handshake
//  --------+-----+------------------------------------+------------------
//  in_ch   | in  | value[31:0], bit_count[5:0]        | valid / ready
//  out_ch  | out | out_byte[7:0], last_of_run         | valid / ready
//
// A word is accepted in any cycle in which the job queue has room; its full
// bytes (up to four) are worked out in that same cycle and queued as one job.
// The back end sends one byte per cycle while out_ch is ready, from a
// registered output stage, so the output port sets the sustained rate. Words
// that complete no byte, and ignored words (a count of zero or beyond the
// field limit), queue nothing. Reset clears the pending bits, empties the
// queue and idles the output stage; the two sides stall independently
// through the queue.
`default_nettype none

module msb_first_bit_packer #(
  parameter int QUEUE_DEPTH = mfbp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mfbp_in_if.sink    in_ch,
  mfbp_out_if.source out_ch
);

  // Handshake between front end and queue, and between queue and back end.
  logic                  push;
  logic                  pop;
  logic                  q_full;
  logic                  q_empty;
  mfbp_pkg::mfbp_entry_t push_entry;
  mfbp_pkg::mfbp_entry_t head;

  // The front end merges each word with the pending bits and queues the
  // bytes it completes; the remainder stays pending there.
  mfbp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // The queue decouples word intake from byte delivery.
  mfbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  // The back end emits each job's bytes in order, marking the final one.
  mfbp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
